// ----- rtl/cbw_pkg.sv -----
// shared types, codes and constant tables of the barcode whitelist corrector
// no dependencies; imported by every rtl module of the block
`default_nettype none
package cbw_pkg;

  localparam int unsigned BARCODE_BASES = 16;
  localparam int unsigned QUAL_CAP      = 33;
  localparam int unsigned DEF_TABLE_DEPTH = 65536;
  localparam int unsigned DEF_PROBE_LIMIT = 8;
  localparam logic [9:0]  THR_RESET     = 10'd975;
  localparam logic [9:0]  SCALE_MILLE   = 10'd1000;

  // item kinds after classification
  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_TAL = 2'd2;
  localparam logic [1:0] OP_COR = 2'd3;

  // input commands
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_TALLY   = 2'd1;
  localparam logic [1:0] CMD_CORRECT = 2'd2;

  // candidate modes for a correction
  localparam logic [1:0] MODE_ALL  = 2'd0; // no unknown base: all substitutions
  localparam logic [1:0] MODE_ONE  = 2'd1; // one unknown base: four bases there
  localparam logic [1:0] MODE_NONE = 2'd2; // several unknown bases: nothing

  // result status codes
  localparam logic [2:0] ST_EXACT = 3'd0;
  localparam logic [2:0] ST_CORR  = 3'd1;
  localparam logic [2:0] ST_NOT   = 3'd2;
  localparam logic [2:0] ST_INS   = 3'd3;
  localparam logic [2:0] ST_TALLY = 3'd4;
  localparam logic [2:0] ST_FULL  = 3'd5;

  // configuration register addresses
  localparam logic [2:0] ADDR_THR = 3'd0;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  mode;
    logic [3:0]  unk_pos;
    logic [31:0] bases;
    logic [95:0] qual;
    logic [31:0] hash;
  } cbw_item_t;

  typedef logic [0:63][31:0] hterm_tab_t;
  typedef logic [0:33][24:0] pedit_tab_t;

  // error likelihood per phred value, q1.24
  localparam pedit_tab_t PEDIT_Q24 = '{
    25'd16777216, 25'd13326616, 25'd10585708, 25'd8408526, 25'd6679130,
    25'd5305422,  25'd4214246,  25'd3347495,  25'd2659010, 25'd2112126,
    25'd1677722,  25'd1332662,  25'd1058571,  25'd840853,  25'd667913,
    25'd530542,   25'd421425,   25'd334749,   25'd265901,  25'd211213,
    25'd167772,   25'd133266,   25'd105857,   25'd84085,   25'd66791,
    25'd53054,    25'd42142,    25'd33475,    25'd26590,   25'd21121,
    25'd16777,    25'd13327,    25'd10586,    25'd8409
  };

  // hash contribution of letter l at position p: ascii(l) * 31^(15-p)
  function automatic hterm_tab_t build_hash_terms();
    hterm_tab_t t;
    logic [31:0] pw;
    logic [0:3][31:0] code;
    code = '{32'd65, 32'd67, 32'd71, 32'd84};
    pw = 32'd1;
    for (int p = 15; p >= 0; p--) begin
      for (int l = 0; l < 4; l++) begin
        t[p * 4 + l] = code[l] * pw;
      end
      pw = pw * 32'd31;
    end
    return t;
  endfunction

  localparam hterm_tab_t HASH_TERM = build_hash_terms();

endpackage
`default_nettype wire

// ----- rtl/cbw_front.sv -----
// front end: accepts beats, classifies the command and forms the base hash
// depends on cbw_pkg
`default_nettype none
module cbw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept_en,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [143:0]      in_tdata,
  input  wire logic [1:0]        in_tuser,
  input  wire logic              q_full,
  output logic                   push,
  output cbw_pkg::cbw_item_t     item
);
  import cbw_pkg::*;

  logic             s1_valid_r;
  cbw_item_t        s1_item_r;
  logic [3:0][31:0] psum_r;
  logic [3:0][31:0] psum;
  cbw_item_t        cls;
  logic [31:0]      bases;
  logic [15:0]      mask;
  logic             take;

  assign bases = in_tdata[31:0];
  assign mask  = in_tdata[47:32];
  assign push  = s1_valid_r && !q_full;
  assign in_tready = accept_en && (!s1_valid_r || push);
  assign take  = in_tvalid && in_tready;

  // four partial sums of hash terms
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      psum[g] = '0;
      for (int k = 0; k < 4; k++) begin
        psum[g] = psum[g] + HASH_TERM[{2'(g), 2'(k), bases[2 * (4 * g + k) +: 2]}];
      end
    end
  end

  always_comb begin
    cls         = '0;
    cls.bases   = bases;
    cls.qual    = in_tdata[143:48];
    if (mask == '0) begin
      cls.mode = MODE_ALL;
    end else if ((mask & (mask - 16'd1)) == '0) begin
      cls.mode = MODE_ONE;
    end else begin
      cls.mode = MODE_NONE;
    end
    for (int i = 0; i < 16; i++) begin
      if (mask[i]) cls.unk_pos = 4'(i);
    end
    priority if (in_tuser == CMD_CORRECT) begin
      cls.op = OP_COR;
    end else if (mask != '0) begin
      cls.op = OP_NOP;
    end else if (in_tuser == CMD_INSERT) begin
      cls.op = OP_INS;
    end else if (in_tuser == CMD_TALLY) begin
      cls.op = OP_TAL;
    end else begin
      cls.op = OP_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (push) begin
      s1_valid_r <= 1'b0;
    end
    if (take) begin
      s1_item_r <= cls;
      psum_r    <= psum;
    end
  end

  always_comb begin
    item      = s1_item_r;
    item.hash = psum_r[0] + psum_r[1] + psum_r[2] + psum_r[3];
  end

endmodule
`default_nettype wire

// ----- rtl/cbw_queue.sv -----
// two-entry queue between front end and table engine
// depends on cbw_pkg
`default_nettype none
module cbw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cbw_pkg::cbw_item_t item_in,
  output logic                    full,
  input  wire logic               pop,
  output cbw_pkg::cbw_item_t      item_out,
  output logic                    empty
);
  import cbw_pkg::*;

  cbw_item_t  ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign item_out = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) ent_r[wp_r] <= item_in;
  end

endmodule
`default_nettype wire

// ----- rtl/cbw_back.sv -----
// table engine: hashed whitelist memory, probe sequencer, weighting and decision
// depends on cbw_pkg
`default_nettype none
module cbw_back #(
  parameter int unsigned TABLE_DEPTH = cbw_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned PROBE_LIMIT = cbw_pkg::DEF_PROBE_LIMIT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [9:0]         thr,
  input  wire logic               q_empty,
  input  wire cbw_pkg::cbw_item_t head,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [35:0]             out_tdata,
  output logic [2:0]              out_tuser
);
  import cbw_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned PC_W   = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CAND  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [64:0] mem [TABLE_DEPTH];
  logic [64:0] mem_q_r;

  logic [3:0]        state_r;
  cbw_item_t         it_r;
  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [31:0]       prb_key_r;
  logic [ADDR_W-1:0] prb_slot_r;
  logic [PC_W-1:0]   prb_cnt_r;
  logic              cand_phase_r;
  logic [3:0]        pos_r;
  logic [1:0]        b_r;
  logic [24:0]       p_r;
  logic [31:0]       cnt_r;
  logic [56:0]       w_r;
  logic [63:0]       best_r;
  logic [63:0]       sum_r;
  logic [31:0]       best_key_r;
  logic [3:0]        best_pos_r;
  logic [1:0]        fin_step_r;
  logic [73:0]       acc_a_r;
  logic [73:0]       acc_b_r;
  logic [2:0]        res_status_r;
  logic [31:0]       res_bar_r;
  logic [3:0]        res_pos_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [31:0]       out_bar_r;
  logic [3:0]        out_pos_r;

  logic              q_valid;
  logic [31:0]       q_key;
  logic [31:0]       q_cnt;
  logic              hit;
  logic              more;
  logic              full_win;
  logic              head_probe;
  logic [1:0]        exist;
  logic [31:0]       cand_key;
  logic [31:0]       cand_hash;
  logic              skip;
  logic [5:0]        qv;
  logic [5:0]        qc;
  logic              adv_done;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [64:0]       wr_data;
  logic [31:0]       mul_half;
  logic [9:0]        mul_k;
  logic [41:0]       mul_p;
  logic              out_load;

  assign clearing = clr_r;
  assign pop      = (state_r == S_IDLE) && !q_empty && !clr_r;

  assign q_valid  = mem_q_r[64];
  assign q_key    = mem_q_r[63:32];
  assign q_cnt    = mem_q_r[31:0];
  assign hit      = q_valid && (q_key == prb_key_r);
  assign full_win = q_valid && !hit && (prb_cnt_r == PC_W'(PROBE_LIMIT - 1));
  assign more     = q_valid && !hit && !full_win;

  assign head_probe = (head.op == OP_INS) || (head.op == OP_TAL) ||
                      ((head.op == OP_COR) && (head.mode == MODE_ALL));

  // candidate for the current position and base
  always_comb begin
    exist     = it_r.bases[{pos_r, 1'b0} +: 2];
    cand_key  = it_r.bases;
    cand_key[{pos_r, 1'b0} +: 2] = b_r;
    cand_hash = it_r.hash - HASH_TERM[{pos_r, exist}] + HASH_TERM[{pos_r, b_r}];
    skip      = (it_r.mode == MODE_ALL) && (b_r == exist);
    qv        = it_r.qual[7'(pos_r) * 7'd6 +: 6];
    qc        = (qv > 6'(QUAL_CAP)) ? 6'(QUAL_CAP) : qv;
    adv_done  = (b_r == 2'd3) && ((it_r.mode == MODE_ONE) || (pos_r == 4'd15));
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = prb_slot_r + ADDR_W'(1);
    if (pop && head_probe) begin
      rd_en   = 1'b1;
      rd_addr = head.hash[ADDR_W-1:0];
    end else if (state_r == S_CHECK && more) begin
      rd_en   = 1'b1;
    end else if (state_r == S_CAND && !skip) begin
      rd_en   = 1'b1;
      rd_addr = cand_hash[ADDR_W-1:0];
    end
    wr_en   = 1'b0;
    wr_addr = prb_slot_r;
    wr_data = {1'b1, prb_key_r, 32'd0};
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (state_r == S_CHECK && it_r.op == OP_INS && (hit || !q_valid)) begin
      wr_en   = 1'b1;
    end else if (state_r == S_CHECK && it_r.op == OP_TAL && hit) begin
      wr_en   = 1'b1;
      wr_data = {1'b1, q_key, (q_cnt == '1) ? q_cnt : q_cnt + 32'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  // shared 32x10 multiplier for the final comparison
  always_comb begin
    mul_half = fin_step_r[1] ? (fin_step_r[0] ? sum_r[63:32] : sum_r[31:0])
                             : (fin_step_r[0] ? best_r[63:32] : best_r[31:0]);
    mul_k    = fin_step_r[1] ? thr : SCALE_MILLE;
    mul_p    = 42'(mul_half) * 42'(mul_k);
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) clr_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            if (head_probe) begin
              state_r <= S_CHECK;
            end else if (head.op == OP_NOP) begin
              state_r <= S_DONE;
            end else if (head.mode == MODE_NONE) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_CAND;
            end
          end
        end
        S_CHECK: begin
          if (!more) begin
            if (it_r.op != OP_COR) begin
              state_r <= S_DONE;
            end else if (!cand_phase_r) begin
              state_r <= hit ? S_DONE : S_CAND;
            end else if (hit && q_cnt != '0) begin
              state_r <= S_MUL;
            end else begin
              state_r <= adv_done ? S_FIN : S_CAND;
            end
          end
        end
        S_CAND: begin
          if (skip) begin
            state_r <= adv_done ? S_FIN : S_CAND;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_MUL:  state_r <= S_ACC;
        S_ACC:  state_r <= adv_done ? S_FIN : S_CAND;
        S_FIN:  if (fin_step_r == 2'd3) state_r <= S_CMP;
        S_CMP:  state_r <= S_DONE;
        S_DONE: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end

    // datapath registers
    if (pop) begin
      it_r         <= head;
      res_status_r <= ST_TALLY;
      res_bar_r    <= head.bases;
      res_pos_r    <= 4'd0;
      best_r       <= '0;
      sum_r        <= '0;
      best_key_r   <= head.bases;
      best_pos_r   <= 4'd0;
      fin_step_r   <= 2'd0;
      prb_key_r    <= head.bases;
      prb_slot_r   <= head.hash[ADDR_W-1:0];
      prb_cnt_r    <= '0;
      cand_phase_r <= !head_probe;
      pos_r        <= (head.mode == MODE_ONE) ? head.unk_pos : 4'd0;
      b_r          <= 2'd0;
    end
    if (state_r == S_CHECK) begin
      if (more) begin
        prb_slot_r <= prb_slot_r + ADDR_W'(1);
        prb_cnt_r  <= prb_cnt_r + PC_W'(1);
      end else if (it_r.op == OP_INS) begin
        res_status_r <= full_win ? ST_FULL : ST_INS;
      end else if (it_r.op == OP_COR && !cand_phase_r) begin
        if (hit) res_status_r <= ST_EXACT;
        cand_phase_r <= 1'b1;
      end else if (it_r.op == OP_COR) begin
        if (hit && q_cnt != '0) begin
          cnt_r <= q_cnt;
        end else if (!adv_done) begin
          pos_r <= (b_r == 2'd3) ? pos_r + 4'd1 : pos_r;
          b_r   <= b_r + 2'd1;
        end
      end
    end
    if (state_r == S_CAND) begin
      if (skip) begin
        if (!adv_done) begin
          pos_r <= (b_r == 2'd3) ? pos_r + 4'd1 : pos_r;
          b_r   <= b_r + 2'd1;
        end
      end else begin
        prb_key_r  <= cand_key;
        prb_slot_r <= cand_hash[ADDR_W-1:0];
        prb_cnt_r  <= '0;
        p_r        <= PEDIT_Q24[qc];
      end
    end
    if (state_r == S_MUL) begin
      w_r <= 57'(cnt_r) * 57'(p_r);
    end
    if (state_r == S_ACC) begin
      sum_r <= sum_r + 64'(w_r);
      if (64'(w_r) > best_r) begin
        best_r     <= 64'(w_r);
        best_key_r <= prb_key_r;
        best_pos_r <= pos_r;
      end
      if (!adv_done) begin
        pos_r <= (b_r == 2'd3) ? pos_r + 4'd1 : pos_r;
        b_r   <= b_r + 2'd1;
      end
    end
    if (state_r == S_FIN) begin
      fin_step_r <= fin_step_r + 2'd1;
      unique case (fin_step_r)
        2'd0: acc_a_r <= 74'(mul_p);
        2'd1: acc_a_r <= acc_a_r + {mul_p, 32'd0};
        2'd2: acc_b_r <= 74'(mul_p);
        2'd3: acc_b_r <= acc_b_r + {mul_p, 32'd0};
        default: acc_b_r <= acc_b_r;
      endcase
    end
    if (state_r == S_CMP) begin
      if (acc_a_r > acc_b_r) begin
        res_status_r <= ST_CORR;
        res_bar_r    <= best_key_r;
        res_pos_r    <= best_pos_r;
      end else begin
        res_status_r <= ST_NOT;
      end
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_bar_r    <= res_bar_r;
      out_pos_r    <= res_pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_bar_r};
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

// ----- rtl/cell_barcode_whitelist_corrector_top.sv -----
// top level of the cell barcode whitelist corrector: stream ports, apb register
// depends on cbw_pkg, cbw_front, cbw_queue, cbw_back
`default_nettype none
// Keeps a hashed whitelist of 16-base barcodes with read counts and serves
// three commands on the input stream (in_tuser): insert a whitelist key,
// tally a read barcode, or correct a barcode against the whitelist. Every
// input beat yields exactly one result beat, in order. The front end takes
// a beat, classifies it and sums the hash terms; a two-entry queue decouples
// it from the table engine, which owns the simple dual-port table memory
// (one read and one write per cycle, read data registered). Items are
// handled one at a time by the engine: insert and tally probe from the home
// slot through the probe window. A correction with no unknown base does the
// exact lookup and, on a miss, at each position skips the original base and
// probes each of the 3 substitutions, weighting every whitelisted candidate
// with a nonzero count, then runs the confidence test and forms the result.
// With one unknown base only 4 candidates are tried, with several none is.
// After reset the engine sweeps the whole table to clear it, and in_tready
// stays low during that sweep; register writes are taken throughout.
// TABLE_DEPTH must be a power of two.
module cell_barcode_whitelist_corrector_top #(
  parameter int unsigned TABLE_DEPTH = cbw_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned PROBE_LIMIT = cbw_pkg::DEF_PROBE_LIMIT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // barcode_bases, unknown_mask, quality_low, quality_high
  input  wire logic [1:0]   in_tuser,   // command
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata,  // barcode_out, best_position, zero pad
  output logic [2:0]        out_tuser,  // status
  // register port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import cbw_pkg::*;

  logic       [9:0] thr_r;
  logic             clearing;
  logic             push;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  cbw_item_t        f_item;
  cbw_item_t        q_item;
  logic      [35:0] res_data;

  // confidence threshold register, per mille
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_THR) ? {22'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_THR) begin
      thr_r <= cfg_pwdata[9:0];
    end
  end

  // front end: beat intake, classification, base hash
  cbw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_en (!clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .item      (f_item)
  );

  cbw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .full     (q_full),
    .pop      (pop),
    .item_out (q_item),
    .empty    (q_empty)
  );

  // table engine with output register
  cbw_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .thr        (thr_r),
    .q_empty    (q_empty),
    .head       (q_item),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (res_data),
    .out_tuser  (out_tuser)
  );

  assign out_tdata = {4'd0, res_data};

  // no beat is taken while the table sweep runs
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input beat accepted during table clear");

  // only a correction reports a changed position
  a_pos_only_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_CORR |-> out_tdata[35:32] == 4'd0)
    else $error("best_position set on a non-corrected result");

  // queue never overfills
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("queue overflow");

  // engine never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty && !clearing)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the cell barcode whitelist corrector top level
// depends on cbw_pkg and cell_barcode_whitelist_corrector_top; stream + apb stimulus
`timescale 1ns / 100ps

module tb;
  import cbw_pkg::*;

  localparam int unsigned DEPTH      = 65536;
  localparam int unsigned PROBES     = 8;
  localparam int unsigned CYCLE_CAP  = 4000000;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;   // command with no meaning
  localparam int unsigned PHASE_ITEMS = 450;

  // one expected result beat
  typedef struct {
    logic [2:0]  status;
    logic [31:0] barcode;
    logic [3:0]  position;
  } lookup_result_t;

  // shadow of the whitelist table plus the threshold register
  class whitelist_scoreboard;
    bit             occupied[int];
    logic [31:0]    slot_key[int];
    logic [31:0]    slot_count[int];
    logic [9:0]     threshold;
    lookup_result_t awaited[$];
    int             mismatches;
    int             matched;
    int             corrections;

    function new();
      threshold = THR_RESET;
    endfunction

    function automatic logic [31:0] home_slot(logic [31:0] key);
      logic [31:0] h;
      h = 0;
      for (int i = 0; i < 16; i++) begin
        case (key[2*i +: 2])
          2'd0: h = h * 31 + 32'd65;
          2'd1: h = h * 31 + 32'd67;
          2'd2: h = h * 31 + 32'd71;
          default: h = h * 31 + 32'd84;
        endcase
      end
      return h % DEPTH;
    endfunction

    // present -> slot holds it; absent -> first free slot or DEPTH when window full
    function automatic bit probe(logic [31:0] key, output int slot);
      int s;
      s = home_slot(key);
      for (int i = 0; i < PROBES; i++) begin
        if (!occupied.exists(s)) begin
          slot = s;
          return 0;
        end
        if (slot_key[s] == key) begin
          slot = s;
          return 1;
        end
        s = (s + 1) % DEPTH;
      end
      slot = DEPTH;
      return 0;
    endfunction

    function void note_input(logic [1:0] cmd, logic [31:0] bases, logic [15:0] mask,
                             logic [47:0] ql, logic [47:0] qh);
      lookup_result_t r;
      int slot;
      logic [63:0]  best, sum, w;
      logic [127:0] lhs, rhs;
      logic [5:0]   q;
      logic [31:0]  cand;
      r.status = ST_TALLY;
      r.barcode = bases;
      r.position = 0;
      if (cmd == CMD_INSERT) begin
        if (mask == 0) begin
          if (probe(bases, slot)) begin
            slot_count[slot] = 0;
            r.status = ST_INS;
          end else if (slot < DEPTH) begin
            occupied[slot] = 1;
            slot_key[slot] = bases;
            slot_count[slot] = 0;
            r.status = ST_INS;
          end else begin
            r.status = ST_FULL;
          end
        end
      end else if (cmd == CMD_TALLY) begin
        if (mask == 0 && probe(bases, slot))
          if (slot_count[slot] != 32'hFFFF_FFFF) slot_count[slot] += 1;
      end else if (cmd == CMD_CORRECT) begin
        if (mask == 0 && probe(bases, slot)) begin
          r.status = ST_EXACT;
        end else begin
          best = 0;
          sum = 0;
          for (int p = 0; p < 16; p++) begin
            q = (p < 8) ? ql[6*p +: 6] : qh[6*(p-8) +: 6];
            if (q > 6'(QUAL_CAP)) q = 6'(QUAL_CAP);
            if ((mask & ~(16'd1 << p)) != 0) continue;
            for (int b = 0; b < 4; b++) begin
              if (!mask[p] && 2'(b) == bases[2*p +: 2]) continue;
              cand = bases;
              cand[2*p +: 2] = 2'(b);
              if (probe(cand, slot) && slot_count[slot] != 0) begin
                w = 64'(slot_count[slot]) * 64'(PEDIT_Q24[q]);
                sum += w;
                if (w > best) begin
                  best = w;
                  r.barcode = cand;
                  r.position = 4'(p);
                end
              end
            end
          end
          lhs = 128'(best) * 128'(SCALE_MILLE);
          rhs = 128'(sum) * 128'(threshold);
          if (lhs > rhs) begin
            r.status = ST_CORR;
          end else begin
            r.status = ST_NOT;
            r.barcode = bases;
            r.position = 0;
          end
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [31:0] barcode, logic [3:0] position);
      lookup_result_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d barcode %h", status, barcode);
        return;
      end
      e = awaited.pop_front();
      if (e.status !== status || e.barcode !== barcode || e.position !== position) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st %0d bc %h pos %0d, got st %0d bc %h pos %0d",
                   e.status, e.barcode, e.position, status, barcode, position);
      end else begin
        matched++;
        if (status == ST_CORR) corrections++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;   // barcode_bases, unknown_mask, quality_low, quality_high
  logic [1:0]   in_tuser = '0;   // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;       // barcode_out, best_position, zero pad
  logic [2:0]   out_tuser;       // status
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  cell_barcode_whitelist_corrector_top #(
    .TABLE_DEPTH(DEPTH),
    .PROBE_LIMIT(PROBES)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  whitelist_scoreboard sb = new();

  bit          idling_on = 1'b1;  // random bursts on both sides
  int          hold_requests = 0; // bumped by the main flow to ask for a long receiver hold
  int          beats_sent = 0;
  int          cycle_count = 0;
  logic [31:0] wl_keys[$];        // whitelist keys inserted so far

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check accepted beats, then pick the next tready
  int hold_left = 0;
  int hold_seen = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[31:0], out_tdata[35:32]);
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 2500;              // long hold so the block backs up into its input
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // present one beat and hold it until taken; optional idle burst afterwards
  task automatic send_item(logic [1:0] cmd, logic [31:0] bases, logic [15:0] mask,
                           logic [47:0] ql, logic [47:0] qh);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {qh, ql, mask, bases};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, bases, mask, ql, qh);
    beats_sent++;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);  // engine may still be finishing up
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_threshold(logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_THR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.threshold = value[9:0];
  endtask

  function automatic logic [47:0] rand_qual();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] substitute(logic [31:0] key, int p);
    logic [31:0] k;
    k = key;
    k[2*p +: 2] = key[2*p +: 2] + 2'($urandom_range(1, 3));
    return k;
  endfunction

  function automatic logic [31:0] pick_key();
    if (wl_keys.size() == 0) return $urandom();
    return wl_keys[$urandom_range(0, wl_keys.size() - 1)];
  endfunction

  // nine keys sharing one home slot: fixed low half, search the upper half
  task automatic collect_same_slot(output logic [31:0] keys[$]);
    logic [31:0] upper_part[];
    logic [31:0] pw[16];
    logic [31:0] lower, low_hash, target, k;
    logic [31:0] codes[4];
    codes = '{32'd65, 32'd67, 32'd71, 32'd84};
    pw[15] = 1;
    for (int p = 14; p >= 0; p--) pw[p] = pw[p+1] * 31;
    upper_part = new[65536];
    for (int j = 0; j < 65536; j++) begin
      upper_part[j] = 0;
      for (int p = 8; p < 16; p++) upper_part[j] += codes[(j >> (2*(p-8))) & 3] * pw[p];
    end
    target = sb.home_slot(32'h5A3C_0000);
    keys = {};
    while (keys.size() < 9) begin
      lower = $urandom_range(0, 65535);
      low_hash = 0;
      for (int p = 0; p < 8; p++) low_hash += codes[(lower >> (2*p)) & 3] * pw[p];
      for (int j = 0; j < 65536 && keys.size() < 9; j++) begin
        if (((low_hash + upper_part[j]) % DEPTH) == target) begin
          k = {j[15:0], lower[15:0]};
          if (!(k inside {keys})) keys.push_back(k);
        end
      end
    end
  endtask

  // one random beat, mostly well-formed whitelist traffic
  task automatic random_item();
    int kind, p, p2;
    logic [31:0] k;
    logic [15:0] m;
    kind = $urandom_range(0, 99);
    p = $urandom_range(0, 15);
    if (kind < 12) begin
      k = $urandom();
      send_item(CMD_INSERT, k, 0, rand_qual(), rand_qual());
      if (wl_keys.size() < 400) wl_keys.push_back(k);
    end else if (kind < 16) begin
      k = substitute(pick_key(), p);    // close neighbour makes corrections compete
      send_item(CMD_INSERT, k, 0, rand_qual(), rand_qual());
      if (wl_keys.size() < 400) wl_keys.push_back(k);
    end else if (kind < 18) begin
      send_item(CMD_INSERT, pick_key(), 0, rand_qual(), rand_qual());
    end else if (kind < 20) begin
      send_item(CMD_INSERT, pick_key(), 16'($urandom_range(1, 65535)), rand_qual(), rand_qual());
    end else if (kind < 45) begin
      send_item(CMD_TALLY, pick_key(), 0, rand_qual(), rand_qual());
    end else if (kind < 48) begin
      m = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom());
      send_item(CMD_TALLY, $urandom(), m, rand_qual(), rand_qual());
    end else if (kind < 58) begin
      send_item(CMD_CORRECT, pick_key(), 0, rand_qual(), rand_qual());
    end else if (kind < 81) begin
      send_item(CMD_CORRECT, substitute(pick_key(), p), 0, rand_qual(), rand_qual());
    end else if (kind < 88) begin
      k = pick_key();
      k[2*p +: 2] = 2'($urandom_range(0, 3));
      send_item(CMD_CORRECT, k, 16'd1 << p, rand_qual(), rand_qual());
    end else if (kind < 92) begin
      p2 = (p + $urandom_range(1, 15)) % 16;
      m = (16'd1 << p) | (16'd1 << p2) | 16'($urandom());
      send_item(CMD_CORRECT, substitute(pick_key(), p), m, rand_qual(), rand_qual());
    end else if (kind < 96) begin
      send_item(CMD_CORRECT, $urandom(), 0, rand_qual(), rand_qual());
    end else begin
      send_item(CMD_UNUSED, $urandom(), 16'($urandom()), rand_qual(), rand_qual());
    end
  endtask

  initial begin
    logic [31:0] crowd[$];
    logic [31:0] seed_key, near;
    logic [9:0]  phase_thr[4];

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, the special cases
    seed_key = 32'h1B6E_93C4;
    near = seed_key;
    near[2*5 +: 2] = seed_key[2*5 +: 2] ^ 2'd1;
    send_item(CMD_INSERT, 32'h0000_0000, 0, 48'h0, 48'h0);                 // all A
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 0, {48{1'b1}}, {48{1'b1}});       // all T
    send_item(CMD_INSERT, seed_key, 0, 48'h0, 48'h0);
    send_item(CMD_INSERT, seed_key, 0, 48'h0, 48'h0);                      // duplicate
    send_item(CMD_INSERT, 32'h1234_5678, 16'hFFFF, 48'h0, 48'h0);          // unknown bases
    send_item(CMD_TALLY, 32'h8765_4321, 0, 48'h0, 48'h0);                  // not whitelisted
    repeat (3) send_item(CMD_TALLY, seed_key, 0, 48'h0, 48'h0);
    send_item(CMD_TALLY, seed_key, 16'h0001, 48'h0, 48'h0);                // masked tally
    send_item(CMD_CORRECT, seed_key, 0, 48'h0, 48'h0);                     // exact
    send_item(CMD_CORRECT, near, 0, {48{1'b1}}, {48{1'b1}});               // one edit, q 63
    send_item(CMD_CORRECT, near, 16'h0020, 48'h0, 48'h0);                  // unknown at edit
    send_item(CMD_CORRECT, near, 16'h8001, 48'h0, 48'h0);                  // two unknowns
    send_item(CMD_CORRECT, 32'hA5A5_A5A5, 0, 48'h0, 48'h0);                // no candidate
    send_item(CMD_UNUSED, seed_key, 0, 48'h0, 48'h0);
    send_item(CMD_CORRECT, 32'h0000_0000, 16'hFFFF, {48{1'b1}}, 48'h0);
    collect_same_slot(crowd);
    foreach (crowd[i]) send_item(CMD_INSERT, crowd[i], 0, 48'h0, 48'h0);  // last one: full
    send_item(CMD_TALLY, crowd[7], 0, 48'h0, 48'h0);
    send_item(CMD_CORRECT, crowd[8], 0, 48'h0, 48'h0);
    wl_keys.push_back(seed_key);
    for (int i = 0; i < 8; i++) wl_keys.push_back(crowd[i]);
    drain();

    // random phases over several thresholds; the last runs without idling
    phase_thr = '{10'd0, 10'd1023, 10'($urandom_range(0, 1000)), 10'd975};
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(32'(phase_thr[ph]));
      if (ph == 3) idling_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 100) hold_requests++;
        random_item();
      end
      drain();
    end
    write_threshold(32'd1000);
    for (int n = 0; n < 20; n++) random_item();
    drain();

    $display("sent %0d beats, %0d results matched, %0d accepted corrections, %0d keys",
             beats_sent, sb.matched, sb.corrections, wl_keys.size());
    $display("thresholds 975, 0, 1023, %0d, 975, 1000; one long result hold", phase_thr[2]);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.awaited.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
